// ===== src/asrf_pkg.sv =====
// shared types and constants for the audio sample ring fifo
// item and result words, command codes and the percentage divider response
package asrf_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int SMP_W     = 16;
    localparam int PEEK_W    = 10;
    localparam int MAG_W     = 15;
    localparam int COUNT_W   = 16;
    localparam int PCT_W     = 7;
    localparam int PCT_SCALE = 100;

    localparam logic [2:0] CMD_PUSH     = 3'd0;
    localparam logic [2:0] CMD_POP      = 3'd1;
    localparam logic [2:0] CMD_PEEK     = 3'd2;
    localparam logic [2:0] CMD_CLEAR    = 3'd3;
    localparam logic [2:0] CMD_PEAK_RST = 3'd4;
    localparam logic [2:0] CMD_STAT_RST = 3'd5;
    // spare codes, no operation
    localparam logic [2:0] CMD_SPARE_A  = 3'd6;
    localparam logic [2:0] CMD_SPARE_B  = 3'd7;

    typedef struct packed {
        logic [2:0]              cmd;
        logic signed [SMP_W-1:0] sample_in;
        logic [PEEK_W-1:0]       peek_offset;
        logic                    burst_last;
    } item_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_out;
        logic                    sample_valid;
        logic                    push_accepted;
        logic [PEEK_W-1:0]       fill_count;
        logic [PEEK_W-1:0]       free_count;
        logic [PCT_W-1:0]        fill_percent;
        logic [MAG_W-1:0]        peak_level;
        logic [COUNT_W-1:0]      overrun_count;
        logic [COUNT_W-1:0]      underrun_count;
        logic                    is_empty;
        logic                    is_full;
    } result_t;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quotient;
    } pct_rsp_t;

endpackage

// ===== src/asrf_item_if.sv =====
// valid/ready channel carrying one command word into the fifo
// depends on asrf_pkg for the item_t word layout
interface asrf_item_if;
    import asrf_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/asrf_result_if.sv =====
// valid/ready channel carrying one status word out of the fifo
// depends on asrf_pkg for the result_t word layout
interface asrf_result_if;
    import asrf_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/asrf_mem.sv =====
// sample storage: one write port, one read port, registered read data
// depends on asrf_pkg for SMP_W and the default depth
module asrf_mem #(
    parameter int DEPTH = asrf_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH)-1:0]          waddr,
    input  logic signed [asrf_pkg::SMP_W-1:0] wdata,
    input  logic                              re,
    input  logic [$clog2(DEPTH)-1:0]          raddr,
    output logic signed [asrf_pkg::SMP_W-1:0] rdata
);
    import asrf_pkg::*;

    logic signed [SMP_W-1:0] mem [DEPTH];
    logic signed [SMP_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/asrf_pct_div.sv =====
// fill percentage: fill*100 times a rounded-up reciprocal of the depth, two registered stages
// depends on asrf_pkg for PCT_W, PCT_SCALE and pct_rsp_t
module asrf_pct_div #(
    parameter int DEPTH = asrf_pkg::DEPTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [$clog2(DEPTH)+asrf_pkg::PCT_W-1:0] dividend,
    output asrf_pkg::pct_rsp_t                      rsp
);
    import asrf_pkg::*;

    localparam int     DIV_W   = $clog2(DEPTH) + PCT_W;
    localparam longint NUM_MAX = longint'(DEPTH - 1) * longint'(PCT_SCALE);
    // shift wide enough that the rounded-up reciprocal never lifts a quotient
    localparam int     SHIFT   = $clog2(NUM_MAX * longint'(DEPTH));
    localparam longint RECIP   = ((longint'(1) << SHIFT) + longint'(DEPTH) - 1) /
                                 longint'(DEPTH);
    localparam int     RECIP_W = $clog2(RECIP + 1);
    localparam int     PROD_W  = DIV_W + RECIP_W;

    logic              stage_reg;
    logic              done_reg;
    logic [DIV_W-1:0]  num_reg;
    logic [PCT_W-1:0]  quo_reg;
    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(num_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            if (start)
            begin
                done_reg <= 1'b0;
            end
            else if (stage_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
        end
        if (stage_reg)
        begin
            quo_reg <= prod[SHIFT +: PCT_W];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== src/audio_sample_ring_fifo.sv =====
// audio sample ring fifo, top level: pointers, statistics and the command sequencer
// one item is taken at a time, only in the idle state; its result is loaded into the output register
// after the memory access, the percentage operand capture and the reciprocal multiply, once that register is free
// the next item is taken while a finished result still waits in the output register
// reset clears pointers, peak, counters and burst flags; sample storage is not cleared
module audio_sample_ring_fifo #(
    parameter int DEPTH = asrf_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    asrf_item_if.sink     item,
    asrf_result_if.source result
);
    import asrf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = PTR_W + 1;
    localparam int EXT_W = PTR_W + PEEK_W;
    localparam int SUM_W = ((PTR_W > PEEK_W) ? PTR_W : PEEK_W) + 1;
    localparam int DIV_W = PTR_W + PCT_W;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(DEPTH - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_DIV} state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [MAG_W-1:0]   peak_reg, peak_next;
    logic [COUNT_W-1:0] ovr_reg, ovr_next;
    logic [COUNT_W-1:0] und_reg, und_next;
    logic               dropped_reg, dropped_next;
    logic               short_reg, short_next;
    logic               hit_reg, hit_next;
    logic               acc_reg, acc_next;
    logic               res_valid_reg, res_valid_next;
    result_t            res_data_reg;

    logic [LVL_W-1:0]   fill_wide;
    logic [PTR_W-1:0]   fill;
    logic [PTR_W-1:0]   free;
    logic [EXT_W-1:0]   fill_ext;
    logic [EXT_W-1:0]   free_ext;
    logic [SUM_W-1:0]   ofs_ext;
    logic [SUM_W-1:0]   pos_sum;
    logic [SUM_W-1:0]   pos_wrap;
    logic               peek_hit;
    logic [MAG_W-1:0]   mag;
    logic               take;
    logic               load_res;

    logic               mem_we;
    logic               mem_re;
    logic [PTR_W-1:0]   mem_raddr;
    logic signed [SMP_W-1:0] mem_rdata;
    logic [DIV_W-1:0]   dividend;
    pct_rsp_t           pct_rsp;

    // level from the pointers, one slot always kept free
    assign fill_wide = (wp_reg >= rp_reg) ? (LVL_W'(wp_reg) - LVL_W'(rp_reg))
                                          : (LVL_W'(DEPTH) - LVL_W'(rp_reg) + LVL_W'(wp_reg));
    assign fill      = fill_wide[PTR_W-1:0];
    assign free      = PTR_LAST - fill;
    assign fill_ext  = EXT_W'(fill);
    assign free_ext  = EXT_W'(free);

    assign ofs_ext  = SUM_W'(item.data.peek_offset);
    assign peek_hit = (ofs_ext < SUM_W'(fill));
    assign pos_sum  = SUM_W'(rp_reg) + ofs_ext;
    assign pos_wrap = (pos_sum >= SUM_W'(DEPTH)) ? (pos_sum - SUM_W'(DEPTH)) : pos_sum;

    // most negative sample counts as full scale
    always_comb
    begin
        if (!item.data.sample_in[SMP_W-1])
        begin
            mag = item.data.sample_in[MAG_W-1:0];
        end
        else if (item.data.sample_in[MAG_W-1:0] == '0)
        begin
            mag = '1;
        end
        else
        begin
            mag = MAG_W'(-item.data.sample_in);
        end
    end

    assign item.ready = (state_reg == ST_IDLE);
    assign take       = item.valid && item.ready;
    assign load_res   = (state_reg == ST_DIV) && pct_rsp.done &&
                        (!res_valid_reg || result.ready);
    assign dividend   = DIV_W'(fill) * DIV_W'(PCT_SCALE);

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        peak_next      = peak_reg;
        ovr_next       = ovr_reg;
        und_next       = und_reg;
        dropped_next   = dropped_reg;
        short_next     = short_reg;
        hit_next       = hit_reg;
        acc_next       = acc_reg;
        res_valid_next = res_valid_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = rp_reg;

        if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_CALC;
                    hit_next   = 1'b0;
                    acc_next   = 1'b0;
                    case (item.data.cmd)
                        CMD_PUSH:
                        begin
                            if (free != '0)
                            begin
                                mem_we   = 1'b1;
                                wp_next  = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                                acc_next = 1'b1;
                                if (mag > peak_reg)
                                begin
                                    peak_next = mag;
                                end
                            end
                            if (item.data.burst_last)
                            begin
                                if (dropped_reg || (free == '0))
                                begin
                                    ovr_next = (ovr_reg == COUNT_MAX) ? ovr_reg : ovr_reg + 1'b1;
                                end
                                dropped_next = 1'b0;
                            end
                            else if (free == '0)
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            if (fill != '0)
                            begin
                                mem_re   = 1'b1;
                                hit_next = 1'b1;
                                rp_next  = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
                            end
                            if (item.data.burst_last)
                            begin
                                if (short_reg || (fill == '0))
                                begin
                                    und_next = (und_reg == COUNT_MAX) ? und_reg : und_reg + 1'b1;
                                end
                                short_next = 1'b0;
                            end
                            else if (fill == '0)
                            begin
                                short_next = 1'b1;
                            end
                        end
                        CMD_PEEK:
                        begin
                            if (peek_hit)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = pos_wrap[PTR_W-1:0];
                                hit_next  = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            wp_next = '0;
                            rp_next = '0;
                        end
                        CMD_PEAK_RST:
                        begin
                            peak_next = '0;
                        end
                        CMD_STAT_RST:
                        begin
                            ovr_next     = '0;
                            und_next     = '0;
                            dropped_next = 1'b0;
                            short_next   = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CALC:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (load_res)
                begin
                    state_next     = ST_IDLE;
                    res_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            peak_reg      <= '0;
            ovr_reg       <= '0;
            und_reg       <= '0;
            dropped_reg   <= 1'b0;
            short_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            acc_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            peak_reg      <= peak_next;
            ovr_reg       <= ovr_next;
            und_reg       <= und_next;
            dropped_reg   <= dropped_next;
            short_reg     <= short_next;
            hit_reg       <= hit_next;
            acc_reg       <= acc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // read data stays in the memory output register until the next access
    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_data_reg.sample_out     <= hit_reg ? mem_rdata : '0;
            res_data_reg.sample_valid   <= hit_reg;
            res_data_reg.push_accepted  <= acc_reg;
            res_data_reg.fill_count     <= fill_ext[PEEK_W-1:0];
            res_data_reg.free_count     <= free_ext[PEEK_W-1:0];
            res_data_reg.fill_percent   <= pct_rsp.quotient;
            res_data_reg.peak_level     <= peak_reg;
            res_data_reg.overrun_count  <= ovr_reg;
            res_data_reg.underrun_count <= und_reg;
            res_data_reg.is_empty       <= (wp_reg == rp_reg);
            res_data_reg.is_full        <= (free == '0);
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    asrf_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wp_reg),
        .wdata (item.data.sample_in),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    asrf_pct_div #(
        .DEPTH (DEPTH)
    ) u_pct_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_CALC),
        .dividend (dividend),
        .rsp      (pct_rsp)
    );

    // pointers only move on an accepted word
    a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> ($stable(wp_reg) && $stable(rp_reg)))
        else $error("pointer moved without an accepted word");

    // a new result only follows a finished percentage
    a_res_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |-> (pct_rsp.done && (state_reg == ST_DIV)))
        else $error("result loaded before divider finished");

    // accepted word always moves the sequencer through ST_CALC, which starts the divider, to ST_DIV
    a_take_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (state_reg == ST_CALC) ##1 (state_reg == ST_DIV))
        else $error("sequencer skipped the divider start");

    // a push never reports read data, and the fifo is never both empty and full
    a_res_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (!(result.data.push_accepted && result.data.sample_valid) &&
                          !(result.data.is_empty && result.data.is_full)))
        else $error("inconsistent result flags");

endmodule

// ===== tb/tb_audio_sample_ring_fifo.sv =====
// self-checking testbench for audio_sample_ring_fifo: directed and random command words
// are predicted by a status scoreboard and each status word out is compared field by field
// depends on asrf_pkg, asrf_item_if, asrf_result_if and the audio_sample_ring_fifo rtl
`timescale 1ns / 100ps

module tb_audio_sample_ring_fifo;
    import asrf_pkg::*;

    class fifo_status_board;
        localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
        localparam int IDX_W = $clog2(DEPTH_DEF);

        logic signed [SMP_W-1:0] samples [DEPTH_DEF];
        int unsigned wr_ptr = 0;
        int unsigned rd_ptr = 0;
        int unsigned peak = 0;
        int unsigned overruns = 0;
        int unsigned underruns = 0;
        bit push_dropped = 0;
        bit pop_short = 0;
        result_t status_due [$];
        int failures = 0;

        function int unsigned fill_level();
            if (wr_ptr >= rd_ptr)
                return wr_ptr - rd_ptr;
            return DEPTH_DEF - rd_ptr + wr_ptr;
        endfunction

        function int unsigned bump(int unsigned count);
            return (count >= COUNT_MAX) ? COUNT_MAX : count + 1;
        endfunction

        function result_t next_status(item_t w);
            result_t r;
            int unsigned level;
            int unsigned mag;
            r = '0;
            level = fill_level();
            case (w.cmd)
                CMD_PUSH:
                begin
                    if (level < DEPTH_DEF - 1)
                    begin
                        samples[IDX_W'(wr_ptr)] = w.sample_in;
                        wr_ptr = (wr_ptr + 1) % DEPTH_DEF;
                        r.push_accepted = 1'b1;
                        // the most negative sample counts as full scale positive
                        mag = (w.sample_in < 0) ? -int'(w.sample_in) : int'(w.sample_in);
                        if (mag > 32767)
                            mag = 32767;
                        if (mag > peak)
                            peak = mag;
                    end
                    else
                        push_dropped = 1'b1;
                    if (w.burst_last)
                    begin
                        if (push_dropped)
                            overruns = bump(overruns);
                        push_dropped = 1'b0;
                    end
                end
                CMD_POP:
                begin
                    if (level > 0)
                    begin
                        r.sample_out   = samples[IDX_W'(rd_ptr)];
                        r.sample_valid = 1'b1;
                        rd_ptr = (rd_ptr + 1) % DEPTH_DEF;
                    end
                    else
                        pop_short = 1'b1;
                    if (w.burst_last)
                    begin
                        if (pop_short)
                            underruns = bump(underruns);
                        pop_short = 1'b0;
                    end
                end
                CMD_PEEK:
                begin
                    if (w.peek_offset < level)
                    begin
                        r.sample_out   = samples[IDX_W'((rd_ptr + w.peek_offset) % DEPTH_DEF)];
                        r.sample_valid = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    wr_ptr = 0;
                    rd_ptr = 0;
                end
                CMD_PEAK_RST:
                    peak = 0;
                CMD_STAT_RST:
                begin
                    overruns     = 0;
                    underruns    = 0;
                    push_dropped = 1'b0;
                    pop_short    = 1'b0;
                end
                default:
                    ;
            endcase
            level = fill_level();
            r.fill_count     = PEEK_W'(level);
            r.free_count     = PEEK_W'(DEPTH_DEF - 1 - level);
            r.fill_percent   = PCT_W'((level * PCT_SCALE) / DEPTH_DEF);
            r.peak_level     = MAG_W'(peak);
            r.overrun_count  = COUNT_W'(overruns);
            r.underrun_count = COUNT_W'(underruns);
            r.is_empty       = (wr_ptr == rd_ptr);
            r.is_full        = (level == DEPTH_DEF - 1);
            return r;
        endfunction

        function void note_command(item_t w);
            status_due.push_back(next_status(w));
        endfunction

        function void compare_field(string what, longint want, longint got);
            if (want != got)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch %0d: %s expected %0d got %0d", failures, what, want, got);
            end
        endfunction

        function void check_status(result_t got);
            result_t want;
            if (status_due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch %0d: status word with none expected", failures);
                return;
            end
            want = status_due.pop_front();
            compare_field("sample_out", longint'(want.sample_out), longint'(got.sample_out));
            compare_field("sample_valid", longint'(want.sample_valid),
                          longint'(got.sample_valid));
            compare_field("push_accepted", longint'(want.push_accepted),
                          longint'(got.push_accepted));
            compare_field("fill_count", longint'(want.fill_count), longint'(got.fill_count));
            compare_field("free_count", longint'(want.free_count), longint'(got.free_count));
            compare_field("fill_percent", longint'(want.fill_percent),
                          longint'(got.fill_percent));
            compare_field("peak_level", longint'(want.peak_level), longint'(got.peak_level));
            compare_field("overrun_count", longint'(want.overrun_count),
                          longint'(got.overrun_count));
            compare_field("underrun_count", longint'(want.underrun_count),
                          longint'(got.underrun_count));
            compare_field("is_empty", longint'(want.is_empty), longint'(got.is_empty));
            compare_field("is_full", longint'(want.is_full), longint'(got.is_full));
        endfunction

        function int pending();
            return status_due.size();
        endfunction
    endclass

    localparam int FIFO_DEPTH     = DEPTH_DEF;
    localparam int ITEM_TARGET    = 1750;
    localparam int IDLE_PCT       = 35;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;

    asrf_item_if   item_ch ();
    asrf_result_if result_ch ();

    audio_sample_ring_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    fifo_status_board sb;
    int items_sent = 0;
    int idle_cycles = 0;
    bit steady = 1'b0;
    bit hold_ask = 1'b0;
    bit hold_taken = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // status words are checked at the edge where they are taken
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_status(result_ch.data);
    end

    always @(posedge clk)
    begin
        if (rst_n && ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_audio_sample_ring_fifo failed");
            $finish;
        end
    end

    // status word receiver: random stalls, one long hold to back the fifo up
    initial
    begin
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_ask && !hold_taken)
            begin
                hold_taken = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (steady)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input item_t w);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= w;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_command(w);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic item_t make_word(logic [2:0] cmd, logic signed [SMP_W-1:0] smp,
                                        logic [PEEK_W-1:0] offset, logic last);
        item_t w;
        w.cmd         = cmd;
        w.sample_in   = smp;
        w.peek_offset = offset;
        w.burst_last  = last;
        return w;
    endfunction

    function automatic logic signed [SMP_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            3: return '1;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    task automatic run_episode(input bit allow_clear, input int max_burst);
        item_t w;
        int pick;
        int n;
        int unsigned level;
        pick = $urandom_range(0, 99);
        w = item_t'({$urandom, $urandom});
        if (pick < 40)
        begin
            n = $urandom_range(1, max_burst);
            for (int i = 0; i < n; i++)
            begin
                w.cmd        = CMD_PUSH;
                w.sample_in  = random_sample();
                w.burst_last = (i == n - 1);
                send_word(w);
                w.peek_offset = PEEK_W'($urandom);
            end
        end
        else if (pick < 75)
        begin
            n = $urandom_range(1, max_burst);
            for (int i = 0; i < n; i++)
            begin
                w.cmd        = CMD_POP;
                w.burst_last = (i == n - 1);
                send_word(w);
                w.sample_in = SMP_W'($urandom);
            end
        end
        else if (pick < 83)
        begin
            level = sb.fill_level();
            w.cmd = CMD_PEEK;
            if (level > 0 && $urandom_range(0, 2) != 0)
                w.peek_offset = PEEK_W'($urandom_range(0, level - 1));
            send_word(w);
        end
        else if (pick < 87)
        begin
            w.cmd = allow_clear ? CMD_CLEAR : CMD_PEAK_RST;
            send_word(w);
        end
        else if (pick < 91)
        begin
            w.cmd = CMD_PEAK_RST;
            send_word(w);
        end
        else if (pick < 94)
        begin
            w.cmd = CMD_STAT_RST;
            send_word(w);
        end
        else if (pick < 96)
        begin
            w.cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_B : CMD_SPARE_A;
            send_word(w);
        end
        else
            send_word(w);
    endtask

    initial
    begin
        int n;
        sb = new();
        rst_n         = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes, peek range, underrun bursts, peak and statistics resets, spare codes and a clear
        send_word(make_word(CMD_PUSH, 16'sh7fff, '0, 1'b0));
        send_word(make_word(CMD_PUSH, 16'sh8000, '0, 1'b0));
        send_word(make_word(CMD_PUSH, -16'sd1, 10'h3ff, 1'b0));
        send_word(make_word(CMD_PUSH, 16'sd0, '0, 1'b1));
        send_word(make_word(CMD_PEEK, '0, '0, 1'b0));
        send_word(make_word(CMD_PEEK, 16'sh7fff, 10'd3, 1'b1));
        send_word(make_word(CMD_PEEK, '0, 10'd4, 1'b0));
        send_word(make_word(CMD_PEEK, '0, 10'h3ff, 1'b0));
        send_word(make_word(CMD_POP, '0, '0, 1'b0));
        send_word(make_word(CMD_POP, '0, '0, 1'b0));
        send_word(make_word(CMD_POP, '0, '0, 1'b0));
        send_word(make_word(CMD_POP, '0, '0, 1'b0));
        send_word(make_word(CMD_POP, '0, '0, 1'b1));
        send_word(make_word(CMD_POP, '0, '0, 1'b1));
        send_word(make_word(CMD_PUSH, -16'sd32767, '0, 1'b1));
        send_word(make_word(CMD_PEAK_RST, '0, '0, 1'b1));
        send_word(make_word(CMD_PUSH, -16'sd12345, '0, 1'b1));
        send_word(make_word(CMD_POP, '0, '0, 1'b0));
        send_word(make_word(CMD_POP, '0, '0, 1'b0));
        send_word(make_word(CMD_STAT_RST, '0, '0, 1'b1));
        send_word(make_word(CMD_POP, '0, '0, 1'b1));
        send_word(make_word(CMD_SPARE_A, 16'sh7fff, 10'h3ff, 1'b1));
        send_word(make_word(CMD_SPARE_B, '0, '0, 1'b0));
        send_word(make_word(CMD_PUSH, 16'sd100, '0, 1'b1));
        send_word(make_word(CMD_CLEAR, '0, '0, 1'b0));

        // low fill: frequent underruns and clears
        while (items_sent < 325)
            run_episode(1'b1, 6);

        // one long push burst past full, no idling on either side
        steady = 1'b1;
        n = FIFO_DEPTH - 1 - sb.fill_level() + $urandom_range(3, 8);
        for (int i = 0; i < n; i++)
            send_word(make_word(CMD_PUSH, random_sample(), PEEK_W'($urandom), i == n - 1));
        steady = 1'b0;

        // hover near full with the receiver held off at first
        hold_ask = 1'b1;
        while (items_sent < ITEM_TARGET)
            run_episode(1'b0, 8);

        item_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.failures == 0)
            $display("tb_audio_sample_ring_fifo passed");
        else
            $display("tb_audio_sample_ring_fifo failed");
        $finish;
    end
endmodule
